// ===== sv/plbjm_pkg.sv =====
// Shared types, codes and constants for the packet loss, burst and jitter monitor.
package plbjm_pkg;

   localparam int DEF_WINDOW_SLOTS = 100;

   localparam int SEQ_W    = 16;
   localparam int CNT_W    = 16;
   localparam int TIME_W   = 48;
   localparam int NOM_W    = 24;
   localparam int TYPE_W   = 8;
   localparam int JITTER_W = 32;
   localparam int OP_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // EWMA weight: new = old * 7/8 + dev/8
   localparam int EWMA_SHIFT = 3;

   localparam logic [OP_W-1:0] OP_PACKET       = 2'd0;
   localparam logic [OP_W-1:0] OP_REPORT       = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR_JITTER = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_NOMINAL_PERIOD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_MARKER  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NEW_SET_MARKER = 2'd2;

   localparam logic [NOM_W-1:0]  NOMINAL_PERIOD_RST = 24'd1000000;
   localparam logic [TYPE_W-1:0] PERIOD_MARKER_RST  = 8'd32;
   localparam logic [TYPE_W-1:0] NEW_SET_MARKER_RST = 8'd33;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   typedef enum logic [3:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_DECODE,
      ST_MARK_DEV,
      ST_MARK_UPD,
      ST_SLOT,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH,
      ST_REPORT
   } state_type;

   typedef struct packed {
      logic capture;
      logic sweep;
      logic decode_packet;
      logic mark_dev;
      logic mark_update;
      logic write_slot;
      logic scan_read;
      logic scan_finish;
      logic report;
      logic clear_jitter;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            is_period_marker;
      logic            is_new_set;
      logic            slot_zero;
      logic            addr_last;
      logic            out_free;
   } status_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
   endfunction

endpackage

// ===== sv/packet_loss_burst_jitter_monitor_unit.sv =====
// Top level of the packet loss, burst and jitter monitor.
//
//   channel   ports                                      direction
//   req       req_valid/req_ready, operation, type, seq,  in
//             arrival time
//   rsp       rsp_valid/rsp_ready, six statistics fields  out
//   csr       csr_valid/csr_ready, csr_index, csr_data    in
//
// After reset the slot window is swept empty, one entry a cycle, and no item
// is taken until the sweep ends; csr writes are taken at any time.
// An item is decoded first; a report then waits in the report state, a clear or an
// unused code returns to idle, a plain packet writes its slot and a period-marker
// packet first takes the two marker steps; a packet that lands in slot 0 then
// scans the whole window, drains and finishes.
// A waiting report holds the sequencer until the result register frees;
// a new item is taken while an earlier result still waits.
module packet_loss_burst_jitter_monitor_unit #(
   parameter int WINDOW_SLOTS = plbjm_pkg::DEF_WINDOW_SLOTS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [plbjm_pkg::OP_W-1:0]          req_operation,
   input  logic [plbjm_pkg::TYPE_W-1:0]        req_packet_type,
   input  logic [plbjm_pkg::SEQ_W-1:0]         req_sequence_number,
   input  logic [plbjm_pkg::TIME_W-1:0]        req_arrival_time_us,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [plbjm_pkg::CNT_W-1:0]         rsp_lost_in_period,
   output logic [plbjm_pkg::CNT_W-1:0]         rsp_received_in_period,
   output logic [plbjm_pkg::CNT_W-1:0]         rsp_longest_loss_run,
   output logic [plbjm_pkg::CNT_W-1:0]         rsp_loss_run_events,
   output logic [plbjm_pkg::CNT_W-1:0]         rsp_in_order_pairs,
   output logic [plbjm_pkg::JITTER_W-1:0]      rsp_jitter_us,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [plbjm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [plbjm_pkg::CSR_DATA_W-1:0]    csr_data
);
   import plbjm_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   plbjm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   plbjm_dp #(
      .WINDOW_SLOTS (WINDOW_SLOTS)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .req_operation          (req_operation),
      .req_packet_type        (req_packet_type),
      .req_sequence_number    (req_sequence_number),
      .req_arrival_time_us    (req_arrival_time_us),
      .csr_valid              (csr_valid && csr_ready),
      .csr_index              (csr_index),
      .csr_data               (csr_data),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_lost_in_period     (rsp_lost_in_period),
      .rsp_received_in_period (rsp_received_in_period),
      .rsp_longest_loss_run   (rsp_longest_loss_run),
      .rsp_loss_run_events    (rsp_loss_run_events),
      .rsp_in_order_pairs     (rsp_in_order_pairs),
      .rsp_jitter_us          (rsp_jitter_us)
   );

endmodule

// ===== sv/plbjm_ctrl.sv =====
// Sequencer for the monitor: sweeps the window, steps packets, scans and reports.
module plbjm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  plbjm_pkg::status_type  status,
   output plbjm_pkg::cmd_type     cmd
);
   import plbjm_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_SWEEP: begin
            if (status.addr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            case (status.op)
               OP_PACKET: begin
                  state_in = status.is_period_marker ? ST_MARK_DEV : ST_SLOT;
               end
               OP_REPORT: state_in = ST_REPORT;
               default:   state_in = ST_IDLE;
            endcase
         end
         ST_MARK_DEV: state_in = ST_MARK_UPD;
         ST_MARK_UPD: state_in = ST_SLOT;
         ST_SLOT: begin
            state_in = status.slot_zero ? ST_SCAN : ST_IDLE;
         end
         ST_SCAN: begin
            if (status.addr_last) state_in = ST_DRAIN;
         end
         ST_DRAIN:  state_in = ST_FINISH;
         ST_FINISH: state_in = ST_IDLE;
         ST_REPORT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_SWEEP;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_SWEEP: cmd.sweep = 1'b1;
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_DECODE: begin
            cmd.decode_packet = (status.op == OP_PACKET);
            cmd.clear_jitter  = (status.op == OP_CLEAR_JITTER);
         end
         ST_MARK_DEV: cmd.mark_dev    = 1'b1;
         ST_MARK_UPD: cmd.mark_update = 1'b1;
         ST_SLOT:     cmd.write_slot  = 1'b1;
         ST_SCAN:     cmd.scan_read   = 1'b1;
         ST_DRAIN:    cmd = '0;
         ST_FINISH:   cmd.scan_finish = 1'b1;
         ST_REPORT:   cmd.report      = status.out_free;
         default:     cmd = '0;
      endcase
   end

endmodule

// ===== sv/plbjm_dp.sv =====
// Datapath: item registers, slot window memory, loss and jitter counters, result register.
module plbjm_dp #(
   parameter int WINDOW_SLOTS = plbjm_pkg::DEF_WINDOW_SLOTS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  plbjm_pkg::cmd_type                  cmd,
   output plbjm_pkg::status_type               status,
   input  logic [plbjm_pkg::OP_W-1:0]          req_operation,
   input  logic [plbjm_pkg::TYPE_W-1:0]        req_packet_type,
   input  logic [plbjm_pkg::SEQ_W-1:0]         req_sequence_number,
   input  logic [plbjm_pkg::TIME_W-1:0]        req_arrival_time_us,
   input  logic                                csr_valid,
   input  logic [plbjm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [plbjm_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [plbjm_pkg::CNT_W-1:0]         rsp_lost_in_period,
   output logic [plbjm_pkg::CNT_W-1:0]         rsp_received_in_period,
   output logic [plbjm_pkg::CNT_W-1:0]         rsp_longest_loss_run,
   output logic [plbjm_pkg::CNT_W-1:0]         rsp_loss_run_events,
   output logic [plbjm_pkg::CNT_W-1:0]         rsp_in_order_pairs,
   output logic [plbjm_pkg::JITTER_W-1:0]      rsp_jitter_us
);
   import plbjm_pkg::*;

   localparam int SLOT_W    = $clog2(WINDOW_SLOTS);
   localparam int ENTRY_W   = SEQ_W + 1;
   localparam longint unsigned RECIP_L =
      ((64'd1 << 32) + longint'(WINDOW_SLOTS) - 64'd1) / longint'(WINDOW_SLOTS);
   localparam logic [31:0]        RECIP      = RECIP_L[31:0];
   localparam logic [SEQ_W-1:0]   SLOTS_SEQ  = SEQ_W'(WINDOW_SLOTS);
   localparam logic [SLOT_W-1:0]  LAST_ADDR  = SLOT_W'(WINDOW_SLOTS - 1);
   localparam logic [ENTRY_W-1:0] SLOT_EMPTY = {1'b1, {SEQ_W{1'b0}}};

   // item registers
   logic [OP_W-1:0]   op_ff;
   logic [TYPE_W-1:0] ptype_ff;
   logic [SEQ_W-1:0]  seq_ff;
   logic [TIME_W-1:0] time_ff;

   // configuration
   logic [NOM_W-1:0]  nominal_ff;
   logic [TYPE_W-1:0] period_marker_ff;
   logic [TYPE_W-1:0] new_set_marker_ff;

   // working registers
   logic [SEQ_W-1:0]  quot_ff,    quot_in;
   logic [TIME_W-1:0] spacing_ff, spacing_in;
   logic [TIME_W-1:0] dev_ff,     dev_in;
   logic [SLOT_W-1:0] addr_ff,    addr_in;
   logic              rd_valid_ff;
   logic [ENTRY_W-1:0] rd_data_ff;

   // monitor state
   logic [SEQ_W-1:0]    arrival_ff,   arrival_in;
   logic                last_vld_ff,  last_vld_in;
   logic [SEQ_W-1:0]    last_idx_ff,  last_idx_in;
   logic [CNT_W-1:0]    run_ff,       run_in;
   logic [CNT_W-1:0]    lost_ff,      lost_in;
   logic [CNT_W-1:0]    received_ff,  received_in;
   logic [CNT_W-1:0]    max_run_ff,   max_run_in;
   logic [CNT_W-1:0]    events_ff,    events_in;
   logic [CNT_W-1:0]    pairs_ff,     pairs_in;
   logic [CNT_W-1:0]    in_order_ff,  in_order_in;
   logic [JITTER_W-1:0] jitter_ff,    jitter_in;
   logic [TIME_W-1:0]   last_mark_ff, last_mark_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [ENTRY_W-1:0] slots_mem [WINDOW_SLOTS];

   logic [47:0]            quot_prod;
   logic [31:0]            quot_back;
   logic [SEQ_W-1:0]       rem;
   logic [SLOT_W-1:0]      slot;
   logic [TIME_W-1:0]      nom_ext;
   logic [TIME_W-1:0]      half_nom;
   logic [JITTER_W+2:0]    jit_x7;
   logic [JITTER_W:0]      jit_sum;
   logic                   mem_we;
   logic [SLOT_W-1:0]      mem_wa;
   logic [ENTRY_W-1:0]     mem_wd;
   logic                   out_free;

   function automatic logic [47:0] req_seq_mul(input logic [SEQ_W-1:0] s);
      return {{(48-SEQ_W){1'b0}}, s} * {16'd0, RECIP};
   endfunction

   assign quot_prod = req_seq_mul(seq_ff);
   assign quot_back = quot_ff * {{(32-SEQ_W){1'b0}}, SLOTS_SEQ};
   assign rem       = seq_ff - quot_back[SEQ_W-1:0];
   assign slot      = rem[SLOT_W-1:0];
   assign nom_ext   = {{(TIME_W-NOM_W){1'b0}}, nominal_ff};
   assign half_nom  = nom_ext >> 1;
   assign jit_x7    = {jitter_ff, {EWMA_SHIFT{1'b0}}} - {3'b000, jitter_ff};
   assign jit_sum   = {1'b0, jit_x7[JITTER_W+2:EWMA_SHIFT]} +
                      {1'b0, dev_ff[JITTER_W+EWMA_SHIFT-1:EWMA_SHIFT]};
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      status.op               = op_ff;
      status.is_period_marker = (ptype_ff == period_marker_ff);
      status.is_new_set       = (ptype_ff == new_set_marker_ff);
      status.slot_zero        = (rem == '0);
      status.addr_last        = (addr_ff == LAST_ADDR);
      status.out_free         = out_free;
   end

   // slot window memory
   always_comb begin
      mem_we = cmd.write_slot || cmd.sweep || cmd.scan_read;
      mem_wa = cmd.write_slot ? slot : addr_ff;
      mem_wd = cmd.write_slot ? {1'b0, arrival_ff} : SLOT_EMPTY;
   end

   always_ff @(posedge clock) begin
      if (mem_we) slots_mem[mem_wa] <= mem_wd;
      rd_data_ff <= slots_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_operation;
         ptype_ff <= req_packet_type;
         seq_ff   <= req_sequence_number;
         time_ff  <= req_arrival_time_us;
      end
      quot_ff    <= quot_in;
      spacing_ff <= spacing_in;
      dev_ff     <= dev_in;
      if (cmd.report) begin
         rsp_lost_in_period     <= lost_ff;
         rsp_received_in_period <= received_ff;
         rsp_longest_loss_run   <= max_run_ff;
         rsp_loss_run_events    <= events_ff;
         rsp_in_order_pairs     <= in_order_ff;
         rsp_jitter_us          <= jitter_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nominal_ff        <= NOMINAL_PERIOD_RST;
         period_marker_ff  <= PERIOD_MARKER_RST;
         new_set_marker_ff <= NEW_SET_MARKER_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_NOMINAL_PERIOD: nominal_ff        <= csr_data;
            CSR_PERIOD_MARKER:  period_marker_ff  <= csr_data[TYPE_W-1:0];
            CSR_NEW_SET_MARKER: new_set_marker_ff <= csr_data[TYPE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      quot_in      = quot_ff;
      spacing_in   = spacing_ff;
      dev_in       = dev_ff;
      addr_in      = addr_ff;
      arrival_in   = arrival_ff;
      last_vld_in  = last_vld_ff;
      last_idx_in  = last_idx_ff;
      run_in       = run_ff;
      lost_in      = lost_ff;
      received_in  = received_ff;
      max_run_in   = max_run_ff;
      events_in    = events_ff;
      pairs_in     = pairs_ff;
      in_order_in  = in_order_ff;
      jitter_in    = jitter_ff;
      last_mark_in = last_mark_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (cmd.sweep || cmd.scan_read) begin
         addr_in = (addr_ff == LAST_ADDR) ? '0 : addr_ff + SLOT_W'(1);
      end

      if (cmd.decode_packet) begin
         quot_in    = quot_prod[47:32];
         spacing_in = time_ff - last_mark_ff;
         if (status.is_new_set) begin
            received_in = '0;
            lost_in     = '0;
         end else begin
            received_in = sat_inc(received_ff);
         end
      end

      if (cmd.mark_dev) begin
         dev_in = (spacing_ff > nom_ext) ? spacing_ff - nom_ext : nom_ext - spacing_ff;
      end

      if (cmd.mark_update) begin
         last_mark_in = time_ff;
         // only deviations under half a period feed the average
         if (dev_ff < half_nom) begin
            jitter_in = jit_sum[JITTER_W] ? '1 : jit_sum[JITTER_W-1:0];
         end
      end

      if (cmd.clear_jitter) jitter_in = '0;

      if (cmd.write_slot) arrival_in = arrival_ff + SEQ_W'(1);

      // one window entry per cycle, counted in the cycle after its read
      if (rd_valid_ff) begin
         if (rd_data_ff[SEQ_W]) begin
            lost_in = sat_inc(lost_ff);
            run_in  = sat_inc(run_ff);
         end else begin
            if (run_ff > max_run_ff) max_run_in = run_ff;
            if (run_ff > CNT_W'(1)) events_in = sat_inc(events_ff);
            run_in = '0;
            if (last_vld_ff &&
                ({1'b0, last_idx_ff} + 17'd1 == {1'b0, rd_data_ff[SEQ_W-1:0]})) begin
               pairs_in = sat_inc(pairs_ff);
            end
            last_vld_in = 1'b1;
            last_idx_in = rd_data_ff[SEQ_W-1:0];
         end
      end

      if (cmd.scan_finish) begin
         in_order_in = pairs_ff;
         pairs_in    = '0;
         arrival_in  = '0;
      end

      if (cmd.report) begin
         lost_in      = '0;
         received_in  = '0;
         max_run_in   = '0;
         events_in    = '0;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         arrival_ff   <= '0;
         last_vld_ff  <= 1'b0;
         last_idx_ff  <= '0;
         run_ff       <= '0;
         lost_ff      <= '0;
         received_ff  <= '0;
         max_run_ff   <= '0;
         events_ff    <= '0;
         pairs_ff     <= '0;
         in_order_ff  <= '0;
         jitter_ff    <= '0;
         last_mark_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         addr_ff      <= addr_in;
         rd_valid_ff  <= cmd.scan_read;
         arrival_ff   <= arrival_in;
         last_vld_ff  <= last_vld_in;
         last_idx_ff  <= last_idx_in;
         run_ff       <= run_in;
         lost_ff      <= lost_in;
         received_ff  <= received_in;
         max_run_ff   <= max_run_in;
         events_ff    <= events_in;
         pairs_ff     <= pairs_in;
         in_order_ff  <= in_order_in;
         jitter_ff    <= jitter_in;
         last_mark_ff <= last_mark_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
